FILE: rtl/core/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  // Sync byte, which also seeds the running XOR
  localparam logic [7:0] SYNC_BYTE = 8'hAA;

  // Body bytes held before the checksum byte
  localparam int         BODY_CELLS = 9;
  localparam logic [3:0] POS_CHECK  = 4'd9;

  // Bit positions in the flags byte
  localparam int FLAG_TOGGLE    = 0;
  localparam int FLAG_D1        = 1;
  localparam int FLAG_NO_SIGNAL = 2;

  typedef logic [7:0] byte_t;

endpackage

`default_nettype wire

FILE: rtl/core/sfr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_cell
  import sfr_pkg::*;
(
  input  logic  clk,
  input  logic  shift_en,
  input  byte_t d_in,
  output byte_t d_out
);

  byte_t byte_r;

  // One byte of the frame body; moves one cell on each body byte
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= d_in;
    end
  end

  assign d_out = byte_r;

endmodule

`default_nettype wire

FILE: rtl/core/sync_xor_frame_receiver_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Frame receiver for a byte stream: 0xAA starts (or restarts) a frame, nine
// body bytes are shifted into a row of nine byte cells while a running XOR
// is kept, and the tenth byte is compared against that XOR. A new byte may
// be accepted every cycle while in_stall is low. Exactly one output
// transaction is produced per completed frame, through a single output
// register. in_stall rises only when the output register is full and
// stalled and the frame is waiting for its checksum byte; any byte, a sync
// byte included, is held off then, while body bytes and bytes outside a
// frame are still accepted. On a bad checksum all fields are zero except
// d2_on, which reports the unchanged LED enable.
module sync_xor_frame_receiver_unit
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_checksum_ok,
  output logic [7:0]  out_peer_seq,
  output logic        out_d1_on,
  output logic        out_no_signal,
  output logic        out_d2_on,
  output logic [15:0] out_level_mv,
  output logic [15:0] out_peak_mv,
  output logic [15:0] out_trough_mv,
  output logic [7:0]  out_ack_seq
);

  // Frame control state
  logic       in_frame_r, in_frame_nxt;
  logic [3:0] pos_r, pos_nxt;
  byte_t      xor_r, xor_nxt;
  logic       led_r, led_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic        ok_r, ok_nxt;
  logic [7:0]  peer_seq_r, peer_seq_nxt;
  logic        d1_r, d1_nxt;
  logic        no_in_r, no_in_nxt;
  logic        d2_r, d2_nxt;
  logic [15:0] level_r, level_nxt;
  logic [15:0] peak_r, peak_nxt;
  logic [15:0] trough_r, trough_nxt;
  logic [7:0]  ack_r, ack_nxt;

  logic  acc, is_sync, body_byte, last_byte, sum_ok, out_take;
  byte_t flags;
  byte_t chain [0:BODY_CELLS];

  // Handshake
  assign in_stall  = out_valid_r && out_stall && in_frame_r && (pos_r >= POS_CHECK);
  assign acc       = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign is_sync   = (in_rx_byte == SYNC_BYTE);
  assign body_byte = acc && !is_sync && in_frame_r && (pos_r < POS_CHECK);
  assign last_byte = acc && !is_sync && in_frame_r && (pos_r >= POS_CHECK);
  assign sum_ok    = (xor_r == in_rx_byte);

  // Row of byte cells: newest byte enters at cell 0, first body byte ends
  // up at the far end of the row
  assign chain[0] = in_rx_byte;

  for (genvar i = 0; i < BODY_CELLS; i++) begin : g_cell
    sfr_cell u_cell (
      .clk      (clk),
      .shift_en (body_byte),
      .d_in     (chain[i]),
      .d_out    (chain[i+1])
    );
  end

  assign flags = chain[BODY_CELLS-1];

  // Next-state logic
  always_comb begin
    in_frame_nxt  = in_frame_r;
    pos_nxt       = pos_r;
    xor_nxt       = xor_r;
    led_nxt       = led_r;
    out_valid_nxt = out_valid_r && !out_take;
    ok_nxt        = ok_r;
    peer_seq_nxt  = peer_seq_r;
    d1_nxt        = d1_r;
    no_in_nxt     = no_in_r;
    d2_nxt        = d2_r;
    level_nxt     = level_r;
    peak_nxt      = peak_r;
    trough_nxt    = trough_r;
    ack_nxt       = ack_r;

    if (acc && is_sync) begin
      in_frame_nxt = 1'b1;
      pos_nxt      = 4'd0;
      xor_nxt      = SYNC_BYTE;
    end else if (body_byte) begin
      xor_nxt = xor_r ^ in_rx_byte;
      pos_nxt = pos_r + 4'd1;
    end else if (last_byte) begin
      in_frame_nxt  = 1'b0;
      pos_nxt       = 4'd0;
      xor_nxt       = SYNC_BYTE;
      out_valid_nxt = 1'b1;
      ok_nxt        = sum_ok;
      if (sum_ok) begin
        led_nxt      = led_r ^ flags[FLAG_TOGGLE];
        peer_seq_nxt = chain[BODY_CELLS];
        d1_nxt       = flags[FLAG_D1];
        no_in_nxt    = flags[FLAG_NO_SIGNAL];
        d2_nxt       = led_r ^ flags[FLAG_TOGGLE];
        level_nxt    = {chain[BODY_CELLS-2], chain[BODY_CELLS-3]};
        peak_nxt     = {chain[BODY_CELLS-4], chain[BODY_CELLS-5]};
        trough_nxt   = {chain[BODY_CELLS-6], chain[BODY_CELLS-7]};
        ack_nxt      = chain[1];
      end else begin
        peer_seq_nxt = 8'd0;
        d1_nxt       = 1'b0;
        no_in_nxt    = 1'b0;
        d2_nxt       = led_r;
        level_nxt    = 16'd0;
        peak_nxt     = 16'd0;
        trough_nxt   = 16'd0;
        ack_nxt      = 8'd0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      pos_r       <= 4'd0;
      xor_r       <= SYNC_BYTE;
      led_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      pos_r       <= pos_nxt;
      xor_r       <= xor_nxt;
      led_r       <= led_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload registers
  always_ff @(posedge clk) begin
    ok_r       <= ok_nxt;
    peer_seq_r <= peer_seq_nxt;
    d1_r       <= d1_nxt;
    no_in_r    <= no_in_nxt;
    d2_r       <= d2_nxt;
    level_r    <= level_nxt;
    peak_r     <= peak_nxt;
    trough_r   <= trough_nxt;
    ack_r      <= ack_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_checksum_ok = ok_r;
  assign out_peer_seq    = peer_seq_r;
  assign out_d1_on       = d1_r;
  assign out_no_signal   = no_in_r;
  assign out_d2_on       = d2_r;
  assign out_level_mv    = level_r;
  assign out_peak_mv     = peak_r;
  assign out_trough_mv   = trough_r;
  assign out_ack_seq     = ack_r;

  // Position never runs past the checksum slot
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_CHECK)
    else $error("byte position out of range");

  // Outside a frame the position stays cleared
  a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> pos_r == 4'd0)
    else $error("position nonzero outside a frame");

  // An accepted sync byte restarts the frame with a seeded XOR
  a_sync_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_rx_byte == SYNC_BYTE)
    |=> (in_frame_r && pos_r == 4'd0 && xor_r == SYNC_BYTE && !$rose(out_valid_r)))
    else $error("sync byte did not restart the frame");

  // A failed frame carries zero fields apart from d2_on
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !ok_r) |-> (peer_seq_r == 8'd0 && level_r == 16'd0 &&
      peak_r == 16'd0 && trough_r == 16'd0 && ack_r == 8'd0 && !d1_r && !no_in_r))
    else $error("bad frame carries nonzero fields");

  // A newly raised result reports the LED enable as it now stands
  a_led_match: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> d2_r == led_r)
    else $error("d2_on does not match the LED enable");

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import sfr_pkg::*;

  // One decoded frame as seen on the result channel
  typedef struct packed {
    logic        ok;
    logic [7:0]  peer_seq;
    logic        d1_on;
    logic        no_signal;
    logic        d2_on;
    logic [15:0] level_mv;
    logic [15:0] peak_mv;
    logic [15:0] trough_mv;
    logic [7:0]  ack_seq;
  } frame_res_t;

  // Directed row: the byte, and a hand-written frame where one is obvious
  typedef struct packed {
    byte_t      rx;
    logic       typed;
    frame_res_t want;
  } rx_row_t;

  localparam int RAND_ITEMS = 1350;
  localparam int LIMIT      = 200000;
  localparam int IDLE_PCT   = 36;
  localparam int DRAIN      = 16;

  localparam frame_res_t NO_RES = '0;
  // All-ones frame right after reset: LED enable toggles from 0 to 1
  localparam frame_res_t ALL_FF = '{1'b1, 8'hFF, 1'b1, 1'b1, 1'b1,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF};
  // Bad checksum: only d2_on carries the kept LED enable
  localparam frame_res_t BAD_LED1 = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1,
                                      16'h0000, 16'h0000, 16'h0000, 8'h00};

  localparam int DIR_N = 26;
  localparam rx_row_t DIR_TAB [DIR_N] = '{
    // bytes outside a frame, then a partial frame cut by a new sync
    '{8'h00, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
    '{8'hAA, 1'b0, NO_RES}, '{8'h12, 1'b0, NO_RES},
    // good frame, every body bit set
    '{8'hAA, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
    '{8'h55, 1'b1, ALL_FF},
    // all-zero body with a wrong checksum
    '{8'hAA, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h01, 1'b1, BAD_LED1}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_checksum_ok;
  logic [7:0]  out_peer_seq;
  logic        out_d1_on;
  logic        out_no_signal;
  logic        out_d2_on;
  logic [15:0] out_level_mv;
  logic [15:0] out_peak_mv;
  logic [15:0] out_trough_mv;
  logic [7:0]  out_ack_seq;

  frame_res_t  out_res;
  frame_res_t  pending_frames [$];
  int          errors = 0;
  int          cycles = 0;
  int          idle_pct = IDLE_PCT;

  // Receiver state mirrored by the predictor
  logic        rx_in_frame = 1'b0;
  logic [3:0]  rx_pos = 4'd0;
  byte_t       rx_cells [BODY_CELLS];
  byte_t       rx_xor = SYNC_BYTE;
  logic        led_en = 1'b0;

  sync_xor_frame_receiver_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_checksum_ok (out_checksum_ok),
    .out_peer_seq    (out_peer_seq),
    .out_d1_on       (out_d1_on),
    .out_no_signal   (out_no_signal),
    .out_d2_on       (out_d2_on),
    .out_level_mv    (out_level_mv),
    .out_peak_mv     (out_peak_mv),
    .out_trough_mv   (out_trough_mv),
    .out_ack_seq     (out_ack_seq)
  );

  assign out_res = {out_checksum_ok, out_peer_seq, out_d1_on, out_no_signal, out_d2_on,
                    out_level_mv, out_peak_mv, out_trough_mv, out_ack_seq};

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Advance the mirrored receiver by one byte; returns 1 when a frame ends
  function automatic bit decode_rx(input byte_t b, output frame_res_t r);
    byte_t flags;
    r = '0;
    if (b == SYNC_BYTE) begin
      rx_in_frame = 1'b1;
      rx_pos = 4'd0;
      rx_xor = SYNC_BYTE;
      return 1'b0;
    end
    if (!rx_in_frame) return 1'b0;
    if (rx_pos < BODY_CELLS) begin
      rx_cells[rx_pos] = b;
      rx_xor = rx_xor ^ b;
      rx_pos = rx_pos + 4'd1;
      return 1'b0;
    end
    // checksum position
    if (rx_xor == b) begin
      flags = rx_cells[1];
      if (flags[FLAG_TOGGLE]) led_en = ~led_en;
      r.ok        = 1'b1;
      r.peer_seq  = rx_cells[0];
      r.d1_on     = flags[FLAG_D1];
      r.no_signal = flags[FLAG_NO_SIGNAL];
      r.level_mv  = {rx_cells[2], rx_cells[3]};
      r.peak_mv   = {rx_cells[4], rx_cells[5]};
      r.trough_mv = {rx_cells[6], rx_cells[7]};
      r.ack_seq   = rx_cells[8];
    end
    r.d2_on = led_en;
    rx_in_frame = 1'b0;
    rx_pos = 4'd0;
    rx_xor = SYNC_BYTE;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < 50) $display("[%0d] mismatch: %s", cycles, msg);
    errors++;
  endtask

  task automatic check_frame(input frame_res_t got, input frame_res_t want);
    if (got.ok !== want.ok)
      report_mismatch($sformatf("checksum_ok got %0h want %0h", got.ok, want.ok));
    if (got.peer_seq !== want.peer_seq)
      report_mismatch($sformatf("peer_seq got %0h want %0h", got.peer_seq, want.peer_seq));
    if (got.d1_on !== want.d1_on)
      report_mismatch($sformatf("d1_on got %0h want %0h", got.d1_on, want.d1_on));
    if (got.no_signal !== want.no_signal)
      report_mismatch($sformatf("no_signal got %0h want %0h", got.no_signal,
                                want.no_signal));
    if (got.d2_on !== want.d2_on)
      report_mismatch($sformatf("d2_on got %0h want %0h", got.d2_on, want.d2_on));
    if (got.level_mv !== want.level_mv)
      report_mismatch($sformatf("level_mv got %0h want %0h", got.level_mv, want.level_mv));
    if (got.peak_mv !== want.peak_mv)
      report_mismatch($sformatf("peak_mv got %0h want %0h", got.peak_mv, want.peak_mv));
    if (got.trough_mv !== want.trough_mv)
      report_mismatch($sformatf("trough_mv got %0h want %0h", got.trough_mv,
                                want.trough_mv));
    if (got.ack_seq !== want.ack_seq)
      report_mismatch($sformatf("ack_seq got %0h want %0h", got.ack_seq, want.ack_seq));
  endtask

  // Send one byte with random leading gaps; queue what it should produce
  task automatic send_rx(input byte_t b, input bit typed, input frame_res_t typed_want);
    frame_res_t pred;
    bit         has;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = decode_rx(b, pred);
    if (typed) pending_frames.push_back(typed_want);
    else if (has) pending_frames.push_back(pred);
  endtask

  // Body byte: biased toward the extremes, never the sync byte
  function automatic byte_t pick_body();
    byte_t b;
    case ($urandom_range(15))
      0: b = 8'h00;
      1: b = 8'hFF;
      default: begin
        do b = byte_t'($urandom_range(255)); while (b == SYNC_BYTE);
      end
    endcase
    return b;
  endfunction

  // Result side: random stall, check every accepted transaction
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) report_mismatch("result with nothing expected");
      else check_frame(out_res, pending_frames.pop_front());
    end
  end

  // Stimulus
  initial begin
    int    sent;
    int    kind;
    int    body_len;
    byte_t sum;
    byte_t b;
    byte_t chk;
    sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TAB[i])
      send_rx(DIR_TAB[i].rx, DIR_TAB[i].typed, DIR_TAB[i].want);

    while (sent < RAND_ITEMS) begin
      // quiet stretch with no idling on either side
      idle_pct = (sent >= 450 && sent < 750) ? 0 : IDLE_PCT;
      kind = $urandom_range(99);
      if (kind >= 92) begin
        // raw noise, may land inside or outside a frame
        repeat ($urandom_range(1, 6)) send_rx(byte_t'($urandom_range(255)), 1'b0, NO_RES);
      end else begin
        body_len = (kind >= 84) ? $urandom_range(0, 8) : BODY_CELLS;
        send_rx(SYNC_BYTE, 1'b0, NO_RES);
        sum = SYNC_BYTE;
        for (int i = 0; i < body_len; i++) begin
          b = pick_body();
          sum = sum ^ b;
          send_rx(b, 1'b0, NO_RES);
        end
        sent += body_len + 1;
        if (kind < 84) begin
          if (kind < 70) chk = sum;
          else if (kind < 78) begin
            do chk = byte_t'($urandom_range(255)); while (chk == sum || chk == SYNC_BYTE);
          end else chk = SYNC_BYTE;
          send_rx(chk, 1'b0, NO_RES);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    idle_pct = IDLE_PCT;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
